// ===== hw/rtl/dhls_pkg.sv =====
// ----------------------------------------------------------------------------
// dhls_pkg
// shared types and constants for the debounced hysteresis light stepper
// ----------------------------------------------------------------------------
package dhls_pkg;

    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_CAL_OFF   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAL_ON    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_RATIO = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_RATIO = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STEP_UP   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_STEP_DN   = 3'd7;

    localparam logic [15:0] CAL_OFF_RST    = 16'd0;
    localparam logic [15:0] CAL_ON_RST     = 16'd0;
    localparam logic [16:0] LOW_RATIO_RST  = 17'd19661;
    localparam logic [16:0] HIGH_RATIO_RST = 17'd45875;
    localparam logic [7:0]  DEBOUNCE_RST   = 8'd3;
    localparam logic [15:0] COOLDOWN_RST   = 16'd10;
    localparam logic [14:0] STEP_UP_RST    = 15'd256;
    localparam logic [14:0] STEP_DN_RST    = 15'd256;

    localparam logic [16:0] Q16_ONE = 17'h10000;

    typedef enum logic [1:0] {
        ACT_HOLD     = 2'd0,
        ACT_UP       = 2'd1,
        ACT_DOWN     = 2'd2,
        ACT_DISABLED = 2'd3
    } action_t;

    // thresholds and polarity derived from calibration
    typedef struct packed {
        logic        disabled;
        logic        rising;
        logic [16:0] thr_lo;
        logic [16:0] thr_hi;
    } thr_t;

endpackage

// ===== hw/rtl/dhls_thresh.sv =====
// ----------------------------------------------------------------------------
// dhls_thresh
// derives the hysteresis band and polarity from the calibration registers
// ----------------------------------------------------------------------------
module dhls_thresh (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        cal_off,
    input  logic [15:0]        cal_on,
    input  logic [16:0]        low_ratio,
    input  logic [16:0]        high_ratio,
    output dhls_pkg::thr_t     thr
);

    logic           rising;
    logic [15:0]    cal_lo;
    logic [15:0]    span;
    logic [16:0]    low_r;
    logic [16:0]    high_r;
    logic [32:0]    low_prod;
    logic [32:0]    high_prod;
    dhls_pkg::thr_t thr_next;
    dhls_pkg::thr_t thr_reg;

    always_comb
    begin
        rising    = cal_on > cal_off;
        cal_lo    = rising ? cal_off : cal_on;
        span      = rising ? (cal_on - cal_off) : (cal_off - cal_on);
        // ratios above one clamp to one
        low_r     = (low_ratio > dhls_pkg::Q16_ONE) ? dhls_pkg::Q16_ONE : low_ratio;
        high_r    = (high_ratio > dhls_pkg::Q16_ONE) ? dhls_pkg::Q16_ONE : high_ratio;
        low_prod  = {17'd0, span} * {16'd0, low_r};
        high_prod = {17'd0, span} * {16'd0, high_r};

        thr_next.disabled = cal_on == cal_off;
        thr_next.rising   = rising;
        thr_next.thr_lo   = {1'b0, cal_lo} + low_prod[32:16];
        thr_next.thr_hi   = {1'b0, cal_lo} + high_prod[32:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '{disabled: 1'b1, rising: 1'b0, thr_lo: 17'd0, thr_hi: 17'd0};
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

// ===== hw/rtl/debounced_hysteresis_light_stepper.sv =====
// ----------------------------------------------------------------------------
// debounced_hysteresis_light_stepper
// hysteresis comparator with debounce counters that steps a brightness value
//
//   channel  dir  beat contents
//   s_axis   in   tdata[15:0] light_sample, tdata[31:16] brightness_in
//   m_axis   out  tdata[15:0] brightness_out, tdata[17:16] action
//   apb      in   eight registers at byte addresses 0x00..0x1c
//
// one beat per cycle sustained while m_axis is ready; a beat passes through the
// input register, then the result register, before it appears on m_axis
// the band comes from registered multiplies of the calibration span, which
// follow the calibration registers in the next cycle
// rst_n clears counters, cooldown and the valid flags, and loads register
// defaults; a stalled m_axis holds its beat while one more input beat waits
// ----------------------------------------------------------------------------
module debounced_hysteresis_light_stepper (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // light_sample, brightness_in
    // m_axis
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // brightness_out, action, zero pad
    // apb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] cal_off_reg;
    logic [15:0] cal_on_reg;
    logic [16:0] low_ratio_reg;
    logic [16:0] high_ratio_reg;
    logic [7:0]  debounce_reg;
    logic [15:0] cooldown_cnt_reg;
    logic [14:0] step_up_reg;
    logic [14:0] step_dn_reg;

    logic                              wr_en;
    logic [dhls_pkg::REG_IDX_W-1:0]    reg_idx;

    dhls_pkg::thr_t thr;

    logic               in_valid_reg;
    logic [15:0]        sample_reg;
    logic signed [15:0] bright_reg;

    logic [7:0]  dark_hits_reg;
    logic [7:0]  dark_hits_next;
    logic [7:0]  bright_hits_reg;
    logic [7:0]  bright_hits_next;
    logic [15:0] cooldown_left_reg;
    logic [15:0] cooldown_left_next;

    logic                  out_valid_reg;
    logic signed [15:0]    out_bright_reg;
    logic signed [15:0]    out_bright_next;
    dhls_pkg::action_t     out_action_reg;
    dhls_pkg::action_t     out_action_next;

    logic               advance;
    logic [16:0]        thr_hi_eff;
    logic               le_lo;
    logic               ge_hi;
    logic               dark_hit;
    logic               bright_hit;
    logic [7:0]         dh1;
    logic [7:0]         bh1;
    logic signed [16:0] sum_up;
    logic signed [16:0] sum_down;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_off_reg      <= dhls_pkg::CAL_OFF_RST;
            cal_on_reg       <= dhls_pkg::CAL_ON_RST;
            low_ratio_reg    <= dhls_pkg::LOW_RATIO_RST;
            high_ratio_reg   <= dhls_pkg::HIGH_RATIO_RST;
            debounce_reg     <= dhls_pkg::DEBOUNCE_RST;
            cooldown_cnt_reg <= dhls_pkg::COOLDOWN_RST;
            step_up_reg      <= dhls_pkg::STEP_UP_RST;
            step_dn_reg      <= dhls_pkg::STEP_DN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                dhls_pkg::REG_CAL_OFF:    cal_off_reg      <= pwdata[15:0];
                dhls_pkg::REG_CAL_ON:     cal_on_reg       <= pwdata[15:0];
                dhls_pkg::REG_LOW_RATIO:  low_ratio_reg    <= pwdata[16:0];
                dhls_pkg::REG_HIGH_RATIO: high_ratio_reg   <= pwdata[16:0];
                dhls_pkg::REG_DEBOUNCE:   debounce_reg     <= pwdata[7:0];
                dhls_pkg::REG_COOLDOWN:   cooldown_cnt_reg <= pwdata[15:0];
                dhls_pkg::REG_STEP_UP:    step_up_reg      <= pwdata[14:0];
                dhls_pkg::REG_STEP_DN:    step_dn_reg      <= pwdata[14:0];
                default:                  cal_off_reg      <= cal_off_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dhls_pkg::REG_CAL_OFF:    prdata = {16'd0, cal_off_reg};
            dhls_pkg::REG_CAL_ON:     prdata = {16'd0, cal_on_reg};
            dhls_pkg::REG_LOW_RATIO:  prdata = {15'd0, low_ratio_reg};
            dhls_pkg::REG_HIGH_RATIO: prdata = {15'd0, high_ratio_reg};
            dhls_pkg::REG_DEBOUNCE:   prdata = {24'd0, debounce_reg};
            dhls_pkg::REG_COOLDOWN:   prdata = {16'd0, cooldown_cnt_reg};
            dhls_pkg::REG_STEP_UP:    prdata = {17'd0, step_up_reg};
            dhls_pkg::REG_STEP_DN:    prdata = {17'd0, step_dn_reg};
            default:                  prdata = '0;
        endcase
    end

    dhls_thresh u_thresh (
        .clk        (clk),
        .rst_n      (rst_n),
        .cal_off    (cal_off_reg),
        .cal_on     (cal_on_reg),
        .low_ratio  (low_ratio_reg),
        .high_ratio (high_ratio_reg),
        .thr        (thr)
    );

    // flow control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // per-beat decision
    always_comb
    begin
        thr_hi_eff = (thr.thr_hi <= thr.thr_lo) ? (thr.thr_lo + 17'd1) : thr.thr_hi;
        le_lo      = {1'b0, sample_reg} <= thr.thr_lo;
        ge_hi      = {1'b0, sample_reg} >= thr_hi_eff;

        if (thr.rising)
        begin
            dark_hit   = le_lo;
            bright_hit = !le_lo && ge_hi;
        end
        else
        begin
            dark_hit   = ge_hi;
            bright_hit = !ge_hi && le_lo;
        end

        dh1 = 8'd0;
        bh1 = 8'd0;
        if (dark_hit)
        begin
            dh1 = (dark_hits_reg < debounce_reg) ? (dark_hits_reg + 8'd1) : dark_hits_reg;
        end
        else if (bright_hit)
        begin
            bh1 = (bright_hits_reg < debounce_reg) ? (bright_hits_reg + 8'd1)
                                                   : bright_hits_reg;
        end

        sum_up   = 17'(bright_reg) + $signed({2'b00, step_up_reg});
        sum_down = 17'(bright_reg) - $signed({2'b00, step_dn_reg});

        dark_hits_next     = dh1;
        bright_hits_next   = bh1;
        cooldown_left_next = cooldown_left_reg;
        out_bright_next    = bright_reg;
        out_action_next    = dhls_pkg::ACT_HOLD;

        if (thr.disabled)
        begin
            dark_hits_next   = dark_hits_reg;
            bright_hits_next = bright_hits_reg;
            out_action_next  = dhls_pkg::ACT_DISABLED;
        end
        else if (cooldown_left_reg != 16'd0)
        begin
            cooldown_left_next = cooldown_left_reg - 16'd1;
            dark_hits_next     = 8'd0;
            bright_hits_next   = 8'd0;
        end
        else if (dh1 >= debounce_reg)
        begin
            dark_hits_next     = 8'd0;
            cooldown_left_next = cooldown_cnt_reg;
            out_action_next    = dhls_pkg::ACT_UP;
            if (sum_up > 17'sd32767)
            begin
                out_bright_next = 16'sh7fff;
            end
            else
            begin
                out_bright_next = sum_up[15:0];
            end
        end
        else if (bh1 >= debounce_reg)
        begin
            bright_hits_next   = 8'd0;
            cooldown_left_next = cooldown_cnt_reg;
            out_action_next    = dhls_pkg::ACT_DOWN;
            if (sum_down < -17'sd32768)
            begin
                out_bright_next = 16'sh8000;
            end
            else
            begin
                out_bright_next = sum_down[15:0];
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            sample_reg <= s_axis_tdata[15:0];
            bright_reg <= s_axis_tdata[31:16];
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_hits_reg     <= 8'd0;
            bright_hits_reg   <= 8'd0;
            cooldown_left_reg <= 16'd0;
            out_valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                dark_hits_reg     <= dark_hits_next;
                bright_hits_reg   <= bright_hits_next;
                cooldown_left_reg <= cooldown_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_bright_reg <= out_bright_next;
            out_action_reg <= out_action_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_action_reg, out_bright_reg};

`ifndef SYNTHESIS
    // a beat seen during cooldown, while not disabled, always holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && !thr.disabled && cooldown_left_reg != 16'd0)
        |=> (out_action_reg == dhls_pkg::ACT_HOLD))
    else $error("step taken during cooldown");

    // every step reloads the cooldown
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg &&
         (out_action_next == dhls_pkg::ACT_UP || out_action_next == dhls_pkg::ACT_DOWN))
        |=> (cooldown_left_reg == $past(cooldown_cnt_reg)))
    else $error("cooldown not loaded after step");

    // disabled beats leave the counters alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && thr.disabled)
        |=> ($stable(dark_hits_reg) && $stable(bright_hits_reg) && $stable(cooldown_left_reg)))
    else $error("state changed while disabled");
`endif

endmodule
